// File: hw/rtl/assert_macros.svh
// Assertion macros used by integer_bcd_alu_with_ccr.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/ibalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibalu_pkg
// Types and constants of the integer and BCD arithmetic unit.
// ----------------------------------------------------------------------------
package ibalu_pkg;
    localparam int DIV_STEPS = 32;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0, OP_SUB = 5'd1, OP_ADDX = 5'd2, OP_SUBX = 5'd3,
        OP_NEG = 5'd4, OP_NEGX = 5'd5, OP_CMP = 5'd6, OP_ADDA = 5'd7,
        OP_SUBA = 5'd8, OP_CMPA = 5'd9, OP_MULU = 5'd10, OP_MULS = 5'd11,
        OP_DIVU = 5'd12, OP_DIVS = 5'd13, OP_ABCD = 5'd14, OP_SBCD = 5'd15,
        OP_NBCD = 5'd16, OP_EXTW = 5'd17, OP_EXTL = 5'd18, OP_EXTB = 5'd19
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_DIV, ST_DONE
    } state_t;

    // Control from the sequencer to the divide unit.
    typedef struct packed {
        logic start;
        logic step;
    } div_ctl_t;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
endpackage

// File: hw/rtl/ibalu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibalu_div
// Restoring 32 by 17 bit unsigned divider, one quotient bit per cycle while ctl.step is high.
// ----------------------------------------------------------------------------
module ibalu_div
    import ibalu_pkg::*;
(
    input  logic        clk,
    input  div_ctl_t    ctl,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic [31:0] quotient,
    output logic [16:0] remainder
);
    logic [31:0] q_reg;
    logic [16:0] r_reg;
    logic [17:0] trial;

    assign trial = {r_reg, q_reg[31]} - {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (ctl.step)
        begin
            if (!trial[17])
            begin
                r_reg <= trial[16:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[15:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

// File: hw/rtl/integer_bcd_alu_with_ccr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_bcd_alu_with_ccr
// Integer and BCD arithmetic unit with a condition-code register.
// ----------------------------------------------------------------------------
// Usage: one word on s_axis carries an operation; tdata holds mode, size,
// src_value and dest_value from the lowest bit up. One result word leaves
// on m_axis with result_value, write_enable, flags_out and divide_by_zero.
// The flags X N Z V C live in a register that the other operations update;
// ADDA, SUBA, unused modes and a divide by zero leave it unchanged. After
// acceptance the block enters ST_DIV; most modes finish there at once and the
// result is registered with the move to ST_DONE. Divides first load the shared
// divide unit and then run a restoring loop of 32 steps. One operation is in
// flight at a time: s_axis_tready is high only in the idle state, which is
// entered in the cycle after the result word is taken, so no new word is
// accepted before the last result is taken. A result is held until
// m_axis_tready takes it; a stalled receiver holds the block.
// Reset clears the flags and the sequencer; no word is pending afterwards.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module integer_bcd_alu_with_ccr
    import ibalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // mode[4:0], size[6:5], src[38:7], dest[70:39]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result[31:0], we[32], flags[37:33], dbz[38]
);
    state_t state_reg, state_next;
    logic [4:0]  mode_reg;
    logic [1:0]  size_reg;
    logic [31:0] src_reg, dst_reg;
    logic [4:0]  flags_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] res_reg;
    logic        we_reg, dbz_reg;
    logic [31:0] res_c;
    logic        we_c, dbz_c;
    logic [4:0]  f_c;
    logic        fin_c;
    div_ctl_t    dctl;
    logic [31:0] ud, uq, quot;
    logic [16:0] uv, urem;
    logic        accept, go;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);
    assign m_axis_tdata = {1'b0, dbz_reg, flags_reg, we_reg, res_reg};

    // Operand magnitudes for the divider; registered operands are stable.
    logic nd, nv, isdiv;
    assign isdiv = (mode_reg == OP_DIVU) || (mode_reg == OP_DIVS);
    assign nd = (mode_reg == OP_DIVS) && dst_reg[31];
    assign nv = (mode_reg == OP_DIVS) && src_reg[15];
    assign ud = nd ? (32'd0 - dst_reg) : dst_reg;
    assign uv = nv ? (17'h10000 - {1'b0, src_reg[15:0]}) : {1'b0, src_reg[15:0]};

    logic go_reg;
    assign go = go_reg;
    assign dctl = '{start: go_reg,
                    step: (state_reg == ST_DIV) && !go_reg && (cnt_reg != 6'd0)};

    ibalu_div u_div (
        .clk(clk), .ctl(dctl), .dividend(ud), .divisor(uv),
        .quotient(uq), .remainder(urem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DIV;
            ST_DIV:  if (fin_c) state_next = ST_DONE;
            ST_DONE: if (m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath for the whole operation set, evaluated on registered operands.
    always_comb
    begin
        logic [31:0] m, msb, d, s, r, asrc, sq, srm;
        logic [31:0] cv, vv;
        logic        xin, sub, keepx, sticky, nq, ovf, c, v;
        logic [9:0]  bin, rr, low;
        logic [7:0]  bres;
        int          ib, ires, ilow;
        m = (size_reg == SZ_BYTE) ? 32'hFF : (size_reg == SZ_WORD) ? 32'hFFFF : 32'hFFFFFFFF;
        msb = m ^ (m >> 1);
        asrc = size_reg[1] ? src_reg : {{16{src_reg[15]}}, src_reg[15:0]};
        res_c = dst_reg; we_c = 1'b0; dbz_c = 1'b0; f_c = flags_reg;
        fin_c = !isdiv || (cnt_reg == 6'd0 && !go_reg);
        xin = 1'b0; sub = 1'b0; keepx = 1'b0; sticky = 1'b0;
        d = dst_reg; s = src_reg;
        r = '0; cv = '0; vv = '0; quot = uq;
        sq = '0; srm = '0; nq = 1'b0; ovf = 1'b0; c = 1'b0; v = 1'b0;
        bin = '0; rr = '0; low = '0; bres = '0; ib = 0; ires = 0; ilow = 0;
        case (mode_reg)
            OP_ADD, OP_SUB, OP_ADDX, OP_SUBX, OP_NEG, OP_NEGX, OP_CMP, OP_CMPA:
            begin
                sub = (mode_reg != OP_ADD) && (mode_reg != OP_ADDX);
                sticky = (mode_reg == OP_ADDX) || (mode_reg == OP_SUBX) || (mode_reg == OP_NEGX);
                xin = sticky & flags_reg[4];
                keepx = (mode_reg == OP_CMP) || (mode_reg == OP_CMPA);
                if (mode_reg == OP_NEG || mode_reg == OP_NEGX)
                begin
                    d = 32'd0; s = dst_reg;
                end
                if (mode_reg == OP_CMPA)
                begin
                    s = asrc; m = 32'hFFFFFFFF; msb = 32'h80000000;
                end
                d = d & m; s = s & m;
                r = (sub ? (d - s - {31'd0, xin}) : (d + s + {31'd0, xin})) & m;
                if (sub)
                begin
                    cv = (s & ~d) | (r & ~d) | (s & r);
                    vv = (s ^ d) & (r ^ d);
                end
                else
                begin
                    cv = (s & d) | (~r & (s | d));
                    vv = (s ^ r) & (d ^ r);
                end
                f_c[4] = keepx ? flags_reg[4] : |(cv & msb);
                f_c[3] = |(r & msb);
                f_c[2] = sticky ? ((r == 0) && flags_reg[2]) : (r == 0);
                f_c[1] = |(vv & msb);
                f_c[0] = |(cv & msb);
                if (!keepx)
                begin
                    res_c = (dst_reg & ~m) | r; we_c = 1'b1;
                end
            end
            OP_ADDA: begin res_c = dst_reg + asrc; we_c = 1'b1; end
            OP_SUBA: begin res_c = dst_reg - asrc; we_c = 1'b1; end
            OP_MULU, OP_MULS:
            begin
                if (mode_reg == OP_MULU)
                    res_c = dst_reg[15:0] * src_reg[15:0];
                else
                    res_c = 32'($signed(dst_reg[15:0]) * $signed(src_reg[15:0]));
                we_c = 1'b1;
                f_c = {flags_reg[4], res_c[31], res_c == 0, 2'b00};
            end
            OP_DIVU, OP_DIVS:
            begin
                if (src_reg[15:0] == 16'd0)
                    dbz_c = 1'b1;
                else if (mode_reg == OP_DIVS && dst_reg == 32'h80000000 &&
                         src_reg[15:0] == 16'hFFFF)
                begin
                    res_c = 32'd0; we_c = 1'b1; f_c = {flags_reg[4], 4'b0100};
                end
                else
                begin
                    nq = nd ^ nv;
                    quot = uq;
                    if (mode_reg == OP_DIVU) ovf = quot > 32'hFFFF;
                    else ovf = nq ? (quot > 32'h8000) : (quot > 32'h7FFF);
                    sq = nq ? (32'd0 - quot) : quot;
                    srm = nd ? (32'd0 - {15'd0, urem}) : {15'd0, urem};
                    if (ovf)
                        f_c = {flags_reg[4], 4'b1010};
                    else
                    begin
                        res_c = {srm[15:0], sq[15:0]}; we_c = 1'b1;
                        f_c = {flags_reg[4], sq[15], sq[15:0] == 0, 2'b00};
                    end
                end
            end
            OP_ABCD:
            begin
                bin = {2'b0, src_reg[7:0]} + {2'b0, dst_reg[7:0]} + {9'd0, flags_reg[4]};
                low = {6'd0, src_reg[3:0]} + {6'd0, dst_reg[3:0]} + {9'd0, flags_reg[4]};
                rr = bin;
                if (low > 10'd9) rr = rr + 10'd6;
                c = (bin > 10'hFF) || (rr > 10'hFF) || ({2'b0, rr[7:4], 4'b0} > 10'h90);
                if (c) rr = rr + 10'h60;
                bres = rr[7:0];
                v = !bin[7] && bres[7];
                f_c = {c, bres[7], flags_reg[2] && (bres == 0), v, c};
                res_c = {dst_reg[31:8], bres}; we_c = 1'b1;
            end
            OP_SBCD, OP_NBCD:
            begin
                d = (mode_reg == OP_SBCD) ? {24'd0, dst_reg[7:0]} : 32'd0;
                s = (mode_reg == OP_SBCD) ? {24'd0, src_reg[7:0]} : {24'd0, dst_reg[7:0]};
                ib = int'(d) - int'(s) - int'(flags_reg[4]);
                ilow = int'(d[3:0]) - int'(s[3:0]) - int'(flags_reg[4]);
                ires = ib;
                if (ilow < 0) ires = ires - 6;
                c = ib < 0;
                if (c) ires = ires - 96;
                c = c || (ires < 0);
                bres = ires[7:0];
                v = !bres[7] && ib[7];
                if (mode_reg == OP_SBCD && v && !s[7] && d[7] && c) v = 1'b0;
                f_c = {c, bres[7], flags_reg[2] && (bres == 0), v, c};
                res_c = {dst_reg[31:8], bres}; we_c = 1'b1;
            end
            OP_EXTW:
            begin
                res_c = {dst_reg[31:16], {8{dst_reg[7]}}, dst_reg[7:0]}; we_c = 1'b1;
                f_c = {flags_reg[4], dst_reg[7], dst_reg[7:0] == 0, 2'b00};
            end
            OP_EXTL:
            begin
                res_c = {{16{dst_reg[15]}}, dst_reg[15:0]}; we_c = 1'b1;
                f_c = {flags_reg[4], dst_reg[15], dst_reg[15:0] == 0, 2'b00};
            end
            OP_EXTB:
            begin
                res_c = {{24{dst_reg[7]}}, dst_reg[7:0]}; we_c = 1'b1;
                f_c = {flags_reg[4], dst_reg[7], dst_reg[7:0] == 0, 2'b00};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flags_reg <= '0;
            cnt_reg   <= '0;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= accept;
            if (go_reg) cnt_reg <= 6'(DIV_STEPS);
            else if (dctl.step) cnt_reg <= cnt_reg - 6'd1;
            if (state_reg == ST_DIV && fin_c) flags_reg <= f_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_axis_tdata[4:0];
            size_reg <= s_axis_tdata[6:5];
            src_reg  <= s_axis_tdata[38:7];
            dst_reg  <= s_axis_tdata[70:39];
        end
        if (state_reg == ST_DIV && fin_c)
        begin
            res_reg <= res_c;
            we_reg  <= we_c;
            dbz_reg <= dbz_c;
        end
    end

    `ASSERT_IMPL(a_one_side, clk, rst_n, !(s_axis_tready && m_axis_tvalid))
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
                 m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_NEXT(a_go, clk, rst_n, accept, go)
endmodule

// File: test/tb_integer_bcd_alu_with_ccr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_bcd_alu_with_ccr
// Self-checking bench for the integer and BCD arithmetic unit.
// ----------------------------------------------------------------------------
// A table of directed operations runs first: extremes, every mode, divide by
// zero and overflow, the signed minimum over minus one, an unused mode and size
// three. Random operations follow under four phases of sender idling and
// receiver stalls. An internal flag-tracking model predicts each result word
// not typed in the table, and each m_axis word is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_integer_bcd_alu_with_ccr;
    import ibalu_pkg::*;

    localparam logic [4:0] FL_X = 5'b10000;
    localparam logic [4:0] FL_N = 5'b01000;
    localparam logic [4:0] FL_Z = 5'b00100;
    localparam logic [4:0] FL_V = 5'b00010;
    localparam logic [4:0] FL_C = 5'b00001;
    localparam logic [4:0] MODE_UNUSED = 5'd20;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_THREE = 2'd3;
    localparam int RANDOM_OPS = 1500;

    typedef struct {
        logic [4:0]  mode;
        logic [1:0]  size;
        logic [31:0] src;
        logic [31:0] dst;
    } alu_op_t;

    typedef struct {
        logic [31:0] value;
        logic        we;
        logic [4:0]  flags;
        logic        dbz;
    } alu_res_t;

    typedef struct {
        logic [4:0]  mode;
        logic [1:0]  size;
        logic [31:0] src;
        logic [31:0] dst;
        bit          typed;
        logic [31:0] value;
        logic        we;
        logic [4:0]  flags;
        logic        dbz;
    } dir_row_t;

    localparam int NDIR = 26;
    dir_row_t dir_rows [0:NDIR-1] = '{
        '{OP_ADD,  SZ_BYTE,  32'h0,        32'h0,        1, 32'h0,        1, FL_Z, 0},
        '{OP_DIVU, SZ_WORD,  32'h0,        32'h12345678, 1, 32'h12345678, 0, FL_Z, 1},
        '{OP_DIVU, SZ_WORD,  32'h1,        32'h00010000, 1, 32'h00010000, 0,
          FL_N | FL_V, 0},
        '{OP_DIVS, SZ_WORD,  32'hFFFF,     32'h80000000, 1, 32'h0,        1, FL_Z, 0},
        '{MODE_UNUSED, SZ_WORD, 32'h5,     32'hDEADBEEF, 1, 32'hDEADBEEF, 0, FL_Z, 0},
        '{OP_ADD,  SZ_LONG,  32'h1,        32'hFFFFFFFF, 1, 32'h0,        1,
          FL_X | FL_Z | FL_C, 0},
        '{OP_ADDX, SZ_BYTE,  32'h99,       32'hAAAA0001, 0, 0, 0, 0, 0},
        '{OP_SUBX, SZ_WORD,  32'h1,        32'h0,        0, 0, 0, 0, 0},
        '{OP_NEG,  SZ_LONG,  32'h0,        32'h80000000, 0, 0, 0, 0, 0},
        '{OP_NEGX, SZ_BYTE,  32'h0,        32'h0,        0, 0, 0, 0, 0},
        '{OP_CMP,  SZ_BYTE,  32'h80,       32'h7F,       0, 0, 0, 0, 0},
        '{OP_ADDA, SZ_WORD,  32'h8000,     32'h10,       0, 0, 0, 0, 0},
        '{OP_SUBA, SZ_LONG,  32'hFFFFFFFF, 32'h0,        0, 0, 0, 0, 0},
        '{OP_CMPA, SZ_BYTE,  32'h7FFF,     32'h7FFF,     0, 0, 0, 0, 0},
        '{OP_MULU, SZ_WORD,  32'hFFFF,     32'hFFFF,     0, 0, 0, 0, 0},
        '{OP_MULS, SZ_WORD,  32'h8000,     32'h8000,     0, 0, 0, 0, 0},
        '{OP_DIVU, SZ_WORD,  32'hFFFF,     32'hFFFEFFFF, 0, 0, 0, 0, 0},
        '{OP_DIVS, SZ_WORD,  32'hFFFD,     32'hFFFFFFF9, 0, 0, 0, 0, 0},
        '{OP_DIVS, SZ_WORD,  32'h2,        32'h80000000, 0, 0, 0, 0, 0},
        '{OP_ABCD, SZ_BYTE,  32'h99,       32'h99,       0, 0, 0, 0, 0},
        '{OP_SBCD, SZ_BYTE,  32'h01,       32'h00,       0, 0, 0, 0, 0},
        '{OP_NBCD, SZ_BYTE,  32'h0,        32'h0,        0, 0, 0, 0, 0},
        '{OP_EXTW, SZ_WORD,  32'h0,        32'h12340080, 0, 0, 0, 0, 0},
        '{OP_EXTL, SZ_LONG,  32'h0,        32'h00008000, 0, 0, 0, 0, 0},
        '{OP_EXTB, SZ_LONG,  32'h0,        32'hFFFFFF7F, 0, 0, 0, 0, 0},
        '{OP_SUB,  SZ_THREE, 32'h1,        32'h0,        0, 0, 0, 0, 0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    logic [4:0] ccr_model = '0;
    alu_res_t   pending_results[$];
    int         err_count = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         stim_done = 0;

    integer_bcd_alu_with_ccr u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] sx_word(logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic [31:0] sx_byte(logic [31:0] v);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    // Add or subtract at the width of mask. Sticky Z may only clear Z.
    function automatic logic [31:0] add_sub(bit sub, logic [31:0] d, logic [31:0] s,
                                            bit xin, logic [31:0] mask,
                                            inout logic [4:0] f, input bit keep_x,
                                            input bit sticky_z);
        logic [31:0] msb, r, c, v;
        logic [4:0]  nf;
        msb = mask ^ (mask >> 1);
        d &= mask;
        s &= mask;
        r = (sub ? (d - s - xin) : (d + s + xin)) & mask;
        if (sub)
        begin
            c = (s & ~d) | (r & ~d) | (s & r);
            v = (s ^ d) & (r ^ d);
        end
        else
        begin
            c = (s & d) | (~r & (s | d));
            v = (s ^ r) & (d ^ r);
        end
        nf = keep_x ? (f & FL_X) : 5'b0;
        if ((c & msb) != 0)
            nf |= keep_x ? FL_C : (FL_X | FL_C);
        if ((v & msb) != 0)
            nf |= FL_V;
        if ((r & msb) != 0)
            nf |= FL_N;
        if (r == 0)
            nf |= sticky_z ? (f & FL_Z) : FL_Z;
        f = nf;
        return r;
    endfunction

    function automatic void nz_flags(logic [31:0] r, bit word, inout logic [4:0] f);
        f &= FL_X;
        if (word ? r[15] : r[31])
            f |= FL_N;
        if ((word ? r[15:0] : r) == 0)
            f |= FL_Z;
    endfunction

    function automatic void bcd_ccr(logic [7:0] r, bit v, bit c, inout logic [4:0] f);
        logic [4:0] nf;
        nf = f & FL_Z;
        if (r[7])
            nf |= FL_N;
        if (v)
            nf |= FL_V;
        if (c)
            nf |= FL_C | FL_X;
        if (r != 0)
            nf &= ~FL_Z;
        f = nf;
    endfunction

    // Decimal d - s - x on one byte; sbcd drops V in one borrow case.
    function automatic logic [7:0] bcd_minus(logic [7:0] d, logic [7:0] s, bit x,
                                             bit cancel, inout logic [4:0] f);
        int   bin, res, lo;
        bit   borrow, v;
        logic [7:0] r, raw;
        bin = int'(d) - int'(s) - int'(x);
        res = bin;
        lo = int'(d[3:0]) - int'(s[3:0]) - int'(x);
        if (lo < 0)
            res -= 6;
        if (bin < 0)
            res -= 'h60;
        borrow = (bin < 0) || (res < 0);
        r = res[7:0];
        raw = bin[7:0];
        v = (~r[7]) & raw[7];
        if (cancel && v && !s[7] && d[7] && borrow)
            v = 0;
        bcd_ccr(r, v, borrow, f);
        return r;
    endfunction

    function automatic alu_res_t predict_alu(alu_op_t op, inout logic [4:0] f);
        alu_res_t    o;
        logic [31:0] m, asrc, r, dv, q, rm, ud, uv, uq, ur;
        bit          x, ovf, nd, nv, nq, c, v;
        logic [8:0]  bsum;
        logic [9:0]  rr;
        logic [4:0]  lo;
        x = f[4];
        m = (op.size == SZ_BYTE) ? 32'hFF : (op.size == SZ_WORD) ? 32'hFFFF : 32'hFFFFFFFF;
        asrc = (op.size[1]) ? op.src : sx_word(op.src);
        o = '{op.dst, 1'b0, 5'b0, 1'b0};
        case (op.mode)
            OP_ADD, OP_SUB, OP_ADDX, OP_SUBX:
            begin
                r = add_sub(op.mode == OP_SUB || op.mode == OP_SUBX, op.dst, op.src,
                            (op.mode >= OP_ADDX) ? x : 1'b0, m, f, 0, op.mode >= OP_ADDX);
                o.value = (op.dst & ~m) | r;
                o.we = 1;
            end
            OP_NEG, OP_NEGX:
            begin
                r = add_sub(1, 0, op.dst, (op.mode == OP_NEGX) ? x : 1'b0, m, f, 0,
                            op.mode == OP_NEGX);
                o.value = (op.dst & ~m) | r;
                o.we = 1;
            end
            OP_CMP:
                void'(add_sub(1, op.dst, op.src, 0, m, f, 1, 0));
            OP_ADDA:
            begin
                o.value = op.dst + asrc;
                o.we = 1;
            end
            OP_SUBA:
            begin
                o.value = op.dst - asrc;
                o.we = 1;
            end
            OP_CMPA:
                void'(add_sub(1, op.dst, asrc, 0, 32'hFFFFFFFF, f, 1, 0));
            OP_MULU, OP_MULS:
            begin
                if (op.mode == OP_MULU)
                    o.value = {16'h0, op.dst[15:0]} * {16'h0, op.src[15:0]};
                else
                    o.value = sx_word(op.dst) * sx_word(op.src);
                nz_flags(o.value, 0, f);
                o.we = 1;
            end
            OP_DIVU, OP_DIVS:
            begin
                dv = {16'h0, op.src[15:0]};
                if (dv == 0)
                    o.dbz = 1;
                else if (op.mode == OP_DIVS && op.dst == 32'h80000000 && dv == 32'hFFFF)
                begin
                    o.value = 0;
                    f = (f & FL_X) | FL_Z;
                    o.we = 1;
                end
                else
                begin
                    if (op.mode == OP_DIVU)
                    begin
                        q = op.dst / dv;
                        rm = op.dst % dv;
                        ovf = q > 32'hFFFF;
                    end
                    else
                    begin
                        nd = op.dst[31];
                        nv = dv[15];
                        ud = nd ? -op.dst : op.dst;
                        uv = nv ? (32'h10000 - dv) : dv;
                        uq = ud / uv;
                        ur = ud % uv;
                        nq = nd != nv;
                        ovf = nq ? (uq > 32'h8000) : (uq > 32'h7FFF);
                        q = nq ? -uq : uq;
                        rm = nd ? -ur : ur;
                    end
                    if (ovf)
                        f = (f & FL_X) | FL_N | FL_V;
                    else
                    begin
                        o.value = {rm[15:0], q[15:0]};
                        nz_flags(q, 1, f);
                        o.we = 1;
                    end
                end
            end
            OP_ABCD:
            begin
                bsum = op.src[7:0] + op.dst[7:0] + x;
                lo = op.src[3:0] + op.dst[3:0] + x;
                rr = {1'b0, bsum};
                if (lo > 9)
                    rr += 10'd6;
                c = bsum > 9'hFF || rr > 10'hFF || (rr[7:4] > 4'h9);
                if (c)
                    rr += 10'h60;
                v = ~bsum[7] & rr[7];
                bcd_ccr(rr[7:0], v, c, f);
                o.value = {op.dst[31:8], rr[7:0]};
                o.we = 1;
            end
            OP_SBCD:
            begin
                o.value = {op.dst[31:8], bcd_minus(op.dst[7:0], op.src[7:0], x, 1, f)};
                o.we = 1;
            end
            OP_NBCD:
            begin
                o.value = {op.dst[31:8], bcd_minus(8'h0, op.dst[7:0], x, 0, f)};
                o.we = 1;
            end
            OP_EXTW:
            begin
                o.value = {op.dst[31:16], {8{op.dst[7]}}, op.dst[7:0]};
                nz_flags(o.value, 1, f);
                o.we = 1;
            end
            OP_EXTL, OP_EXTB:
            begin
                o.value = (op.mode == OP_EXTL) ? sx_word(op.dst) : sx_byte(op.dst);
                nz_flags(o.value, 0, f);
                o.we = 1;
            end
            default: ;
        endcase
        o.flags = f;
        return o;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
            3: return $urandom_range(0, 300);
            4: return $urandom_range(0, 1) ? 32'hFFFF8000 : 32'h00007FFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] bcd_byte();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic alu_op_t random_op();
        alu_op_t op;
        logic [15:0] dv;
        op.mode = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
                                               : 5'($urandom_range(0, 19));
        op.size = 2'($urandom_range(0, 3));
        op.src = pick_value();
        op.dst = pick_value();
        if ((op.mode == OP_ABCD || op.mode == OP_SBCD || op.mode == OP_NBCD)
            && $urandom_range(0, 3) != 0)
        begin
            op.src[7:0] = bcd_byte();
            op.dst[7:0] = bcd_byte();
        end
        if ((op.mode == OP_DIVU || op.mode == OP_DIVS) && $urandom_range(0, 9) != 0)
        begin
            dv = 16'($urandom);
            if (dv == 0)
                dv = 16'd1;
            op.src[15:0] = dv;
            // Keep most dividends in range so the quotient fits.
            if ($urandom_range(0, 2) != 0)
            begin
                op.dst = $urandom % {1'b0, dv[14:0] | 15'h1, 15'h0};
                if (op.mode == OP_DIVS && $urandom_range(0, 1))
                    op.dst = -op.dst;
            end
        end
        return op;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        err_count++;
    endtask

    // Drives one word and waits for its handshake; the prediction is queued
    // at acceptance, or the typed expectation where the row carries one.
    task automatic send_word(alu_op_t op, bit typed, alu_res_t typed_res);
        alu_res_t p;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, op.dst, op.src, op.size, op.mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        p = predict_alu(op, ccr_model);
        pending_results.push_back(typed ? typed_res : p);
        if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    initial
    begin
        alu_op_t  op;
        alu_res_t want;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NDIR; i++)
        begin
            op = '{dir_rows[i].mode, dir_rows[i].size, dir_rows[i].src, dir_rows[i].dst};
            want = '{dir_rows[i].value, dir_rows[i].we, dir_rows[i].flags, dir_rows[i].dbz};
            send_word(op, dir_rows[i].typed, want);
        end
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            case ((i * 4) / RANDOM_OPS)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            send_word(random_op(), 0, want);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (err_count == 0)
            $display("tb_integer_bcd_alu_with_ccr: done, clean");
        else
            $display("tb_integer_bcd_alu_with_ccr: done, errors");
        $finish;
    end

    // Result side: check each accepted word, then pick the next ready level.
    initial
    begin
        alu_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                    report("unexpected word", m_axis_tdata[31:0], 32'h0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.value)
                        report("result_value", m_axis_tdata[31:0], want.value);
                    if (m_axis_tdata[32] !== want.we)
                        report("write_enable", 32'(m_axis_tdata[32]), 32'(want.we));
                    if (m_axis_tdata[37:33] !== want.flags)
                        report("flags_out", 32'(m_axis_tdata[37:33]), 32'(want.flags));
                    if (m_axis_tdata[38] !== want.dbz)
                        report("divide_by_zero", 32'(m_axis_tdata[38]), 32'(want.dbz));
                end
            end
            m_axis_tready <= rst_n && !(recv_stall_pct > 0
                                        && $urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    initial
    begin
        #20ms;
        $display("tb_integer_bcd_alu_with_ccr: done, errors");
        $finish;
    end
endmodule
